FILE: hdl/xorshift64_ranged_random_assert.svh
// Assertion macros used by the checker file.
`ifndef XORSHIFT64_RANGED_RANDOM_ASSERT_SVH
`define XORSHIFT64_RANGED_RANDOM_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XRR_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("xorshift64_ranged_random: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define XRR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("xorshift64_ranged_random: assertion failed");

`endif

FILE: hdl/xrr_pkg.sv
`timescale 1ns / 1ps

package xrr_pkg;

	localparam int DataW    = 64;
	localparam int DivSteps = DataW;
	localparam int CntW     = $clog2(DivSteps);

	localparam int ShiftA = 21;
	localparam int ShiftB = 35;
	localparam int ShiftC = 4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_DONE
	} xrr_state_t;

	typedef struct packed {
		logic load_seed;
		logic accept;
		logic prep;
		logic step;
		logic finish;
	} xrr_cmd_t;

	typedef struct packed {
		logic last_step;
	} xrr_status_t;

	function automatic logic [DataW-1:0] xrr_advance(input logic [DataW-1:0] s);
		logic [DataW-1:0] t;
		t = s ^ (s << ShiftA);
		t = t ^ (t >> ShiftB);
		t = t ^ (t << ShiftC);
		return t;
	endfunction

endpackage

FILE: hdl/xrr_ctrl.sv
`timescale 1ns / 1ps

module xrr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	output xrr_pkg::xrr_cmd_t   cmd,
	input  xrr_pkg::xrr_status_t status
);
	import xrr_pkg::*;

	xrr_state_t state_q;
	xrr_state_t state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (status.last_step) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_stall  = 1'b1;
		cfg_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall      = 1'b0;
				cfg_ready     = !in_valid;
				cmd.accept    = in_valid;
				cmd.load_seed = cfg_valid && !in_valid;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
			end
			ST_DONE: begin
				cmd.finish = slot_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: hdl/xrr_dp.sv
`timescale 1ns / 1ps

module xrr_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  xrr_pkg::xrr_cmd_t    cmd,
	output xrr_pkg::xrr_status_t status,
	input  logic [63:0]          seed_value,
	input  logic [63:0]          min_value,
	input  logic [63:0]          max_value,
	output logic [63:0]          rand_value
);
	import xrr_pkg::*;

	localparam logic [CntW-1:0] CntLast = CntW'(DivSteps - 1);

	logic [DataW-1:0] gen_q;
	logic [DataW-1:0] min_q;
	logic [DataW-1:0] span_q;
	logic             full_q;
	logic [DataW-1:0] rem_q;
	logic [DataW-1:0] dvd_q;
	logic [CntW-1:0]  cnt_q;
	logic [DataW-1:0] rand_q;
	logic [DataW+1:0] trial;
	logic [DataW-1:0] offset;

	// One restoring division step: bring down the next dividend bit and subtract the span.
	assign trial  = {1'b0, rem_q, dvd_q[DataW-1]} - {2'b00, span_q};
	assign offset = full_q ? gen_q : rem_q;

	assign status.last_step = (cnt_q == CntLast);
	assign rand_value       = rand_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cmd.load_seed) begin
				gen_q <= seed_value;
			end else if (cmd.accept) begin
				gen_q <= xrr_advance(gen_q);
			end
			if (cmd.prep) begin
				cnt_q <= '0;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			min_q  <= min_value;
			span_q <= max_value - min_value + 64'd1;
		end
		if (cmd.prep) begin
			full_q <= (span_q == '0);
			rem_q  <= '0;
			dvd_q  <= gen_q;
		end else if (cmd.step) begin
			dvd_q <= {dvd_q[DataW-2:0], 1'b0};
			if (!trial[DataW+1]) begin
				rem_q <= trial[DataW-1:0];
			end else begin
				rem_q <= {rem_q[DataW-2:0], dvd_q[DataW-1]};
			end
		end
		if (cmd.finish) begin
			rand_q <= min_q + offset;
		end
	end

endmodule

FILE: hdl/xorshift64_ranged_random.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// request   in         in_valid / in_stall    min_value, max_value
// result    out        out_valid / out_stall  rand_value
// seed      in         cfg_valid / cfg_ready  seed_value
//
// A request is accepted and the generator state advanced, then it is set up,
// then reduced by the bit-serial remainder, and then the result register is
// loaded; the next request is accepted only after that load.
// Reset clears the generator state to zero and empties the result register.
// A stalled result waits in its register while the next request is worked on.

module xorshift64_ranged_random (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] min_value,
	input  logic [63:0] max_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] rand_value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [63:0] seed_value
);
	import xrr_pkg::*;

	xrr_cmd_t    cmd;
	xrr_status_t status;

	xrr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cmd       (cmd),
		.status    (status)
	);

	xrr_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.seed_value (seed_value),
		.min_value  (min_value),
		.max_value  (max_value),
		.rand_value (rand_value)
	);

endmodule

FILE: hdl/xrr_chk.sv
`timescale 1ns / 1ps
`include "xorshift64_ranged_random_assert.svh"

module xrr_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] rand_value,
	input logic        cfg_ready
);

	`XRR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(rand_value))
	`XRR_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall)
	`XRR_ASSERT_SAME(a_cfg_when_idle, cfg_ready, !in_stall)
	`XRR_ASSERT_SAME(a_result_at_idle, $rose(out_valid), !in_stall)

endmodule

bind xorshift64_ranged_random xrr_chk u_chk (.*);

FILE: bench/xorshift64_ranged_random_tb.sv
`timescale 1ns / 1ps

module xorshift64_ranged_random_tb;

	localparam int XsLeftA  = 21;
	localparam int XsRight  = 35;
	localparam int XsLeftB  = 4;
	localparam int PhaseLen = 332;
	localparam int HoldLen  = 600;
	localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		bit          load;
		logic [63:0] seed;
		logic [63:0] lo;
		logic [63:0] hi;
		bit          typed;
		logic [63:0] want;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [63:0] min_value;
	logic [63:0] max_value;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] rand_value;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [63:0] seed_value;

	logic [63:0] xs_state;
	logic [63:0] rand_q[$];
	logic [63:0] got_want;
	int          errors;
	int          requests;
	int          results;
	int          seed_loads;
	int          send_idle_pct;
	int          stall_pct;
	int          hold_reqs;
	int          hold_seen;

	dir_row_t dir_rows[19] = '{
		'{1'b0, 64'd0, 64'd0, AllOnes, 1'b1, 64'd0},
		'{1'b0, 64'd0, 64'd5, 64'd3, 1'b1, 64'd5},
		'{1'b0, 64'd0, AllOnes, AllOnes, 1'b1, AllOnes},
		'{1'b0, 64'd0, 64'd1234, 64'd1000000, 1'b1, 64'd1234},
		'{1'b1, AllOnes, 64'd0, AllOnes, 1'b0, 64'd0},
		'{1'b0, 64'd0, AllOnes, AllOnes, 1'b1, AllOnes},
		'{1'b0, 64'd0, 64'd0, 64'd0, 1'b1, 64'd0},
		'{1'b0, 64'd0, AllOnes, AllOnes - 64'd1, 1'b0, 64'd0},
		'{1'b0, 64'd0, 64'd100, 64'd50, 1'b0, 64'd0},
		'{1'b0, 64'd0, 64'd0, 64'd1, 1'b0, 64'd0},
		'{1'b0, 64'd0, 64'd1, AllOnes, 1'b0, 64'd0},
		'{1'b0, 64'd0, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 64'd0},
		'{1'b0, 64'd0, 64'd0, 64'hFFFF_FFFF, 1'b0, 64'd0},
		'{1'b0, 64'd0, 64'd10, 64'd20, 1'b0, 64'd0},
		'{1'b1, 64'd0, 64'd42, 64'd99, 1'b1, 64'd42},
		'{1'b0, 64'd0, AllOnes, 64'd0, 1'b1, AllOnes},
		'{1'b1, 64'd1, 64'd0, AllOnes, 1'b0, 64'd0},
		'{1'b0, 64'd0, 64'd0, 64'd6, 1'b0, 64'd0},
		'{1'b0, 64'd0, 64'd3, 64'd3, 1'b1, 64'd3}
	};

	xorshift64_ranged_random dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.min_value  (min_value),
		.max_value  (max_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.rand_value (rand_value),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.seed_value (seed_value)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] xs_next(input logic [63:0] s);
		logic [63:0] t;
		t = s ^ (s << XsLeftA);
		t = t ^ (t >> XsRight);
		t = t ^ (t << XsLeftB);
		return t;
	endfunction

	function automatic logic [63:0] ranged_pick(input logic [63:0] s, lo, hi);
		logic [63:0] span;
		span = hi - lo + 64'd1;
		if (span == 64'd0) begin
			return lo + s;
		end
		return lo + (s % span);
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] pick_bound();
		case ($urandom_range(0, 9))
			0: begin
				return 64'd0;
			end
			1: begin
				return AllOnes;
			end
			2, 3: begin
				return 64'($urandom_range(0, 1000));
			end
			default: begin
				return rand64();
			end
		endcase
	endfunction

	task automatic flag_mismatch(input string what, input logic [63:0] got, want);
		if (errors < 40) begin
			$display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
		end
		errors++;
	endtask

	task automatic send_request(input logic [63:0] lo, hi, input bit typed,
			input logic [63:0] want);
		int gap;
		if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 90) : $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		min_value <= lo;
		max_value <= hi;
		do @(posedge clk); while (in_stall);
		xs_state = xs_next(xs_state);
		rand_q.push_back(typed ? want : ranged_pick(xs_state, lo, hi));
		requests++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (rand_q.size() != 0) @(posedge clk);
	endtask

	task automatic load_seed(input logic [63:0] v);
		cfg_valid  <= 1'b1;
		seed_value <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		xs_state = v;
		seed_loads++;
	endtask

	task automatic run_phase(input int sidle, rstall, input logic [63:0] seed, input bit hold);
		logic [63:0] lo;
		logic [63:0] hi;
		send_idle_pct = sidle;
		stall_pct     = rstall;
		load_seed(seed);
		for (int i = 0; i < PhaseLen; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					lo = pick_bound();
					hi = lo + (rand64() >> $urandom_range(0, 63));
				end
				4: begin
					lo = rand64();
					hi = lo - 64'd1;
				end
				5: begin
					hi = rand64() >> $urandom_range(1, 63);
					lo = hi + 64'd1 + (rand64() >> $urandom_range(1, 63));
				end
				default: begin
					lo = pick_bound();
					hi = pick_bound();
				end
			endcase
			send_request(lo, hi, 1'b0, 64'd0);
			if (hold && i == PhaseLen / 3) begin
				hold_reqs++;
			end
		end
		drain();
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (rand_q.size() == 0) begin
				flag_mismatch("result with no request", rand_value, 64'd0);
			end else begin
				got_want = rand_q.pop_front();
				if (rand_value !== got_want) begin
					flag_mismatch("rand_value", rand_value, got_want);
				end
				results++;
			end
		end
	end

	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_reqs) begin
				hold_seen = hold_reqs;
				out_stall <= 1'b1;
				repeat (HoldLen) @(posedge clk);
			end else begin
				out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	initial begin
		#(6_000_000);
		$display("[xorshift64_ranged_random] ERROR");
		$finish;
	end

	initial begin
		errors        = 0;
		requests      = 0;
		results       = 0;
		seed_loads    = 0;
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_reqs     = 0;
		hold_seen     = 0;
		xs_state      = 64'd0;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		min_value  <= 64'd0;
		max_value  <= 64'd0;
		cfg_valid  <= 1'b0;
		seed_value <= 64'd0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].load) begin
				drain();
				load_seed(dir_rows[i].seed);
			end
			send_request(dir_rows[i].lo, dir_rows[i].hi, dir_rows[i].typed, dir_rows[i].want);
		end
		drain();

		run_phase(0, 0, rand64(), 1'b1);
		run_phase(73, 0, 64'd1, 1'b0);
		run_phase(0, 73, AllOnes, 1'b0);
		run_phase(29, 29, rand64(), 1'b0);

		repeat (150) @(posedge clk);
		foreach (rand_q[i]) begin
			flag_mismatch("missing result", 64'd0, rand_q[i]);
		end
		$display("Checked %0d results from %0d requests over %0d seed loads.",
			results, requests, seed_loads);
		$display("Ran four handshake mixes with full-span, inverted and single-value ranges.");
		if (errors == 0) begin
			$display("[xorshift64_ranged_random] OK");
		end else begin
			$display("[xorshift64_ranged_random] ERROR");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hdl
hdl/xrr_pkg.sv
hdl/xrr_ctrl.sv
hdl/xrr_dp.sv
hdl/xorshift64_ranged_random.sv
hdl/xrr_chk.sv
bench/xorshift64_ranged_random_tb.sv
